### sv/b58dec_pkg.sv
package b58dec_pkg;

    // Characters and bytes in one full block
    localparam logic [3:0] FULL_CHARS = 4'd11;
    localparam logic [3:0] FULL_BYTES = 4'd8;

    // Default depth of the block queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SYMBOL = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_BAD_LENGTH = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_block;
        logic       end_of_string;
        t_status    status;
    } t_out_item;

    // One finished block (or one error report) waiting to be serialized
    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  nbytes;
        logic        eos;
        t_status     status;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_digit;

    // Map an ASCII character to its base58 digit
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        logic [7:0] t;
        d = '0;
        t = '0;
        if (c >= 8'h31 && c <= 8'h39) begin
            t = c - 8'h31;
            d.ok = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h48) begin
            t = c - 8'h41 + 8'd9;
            d.ok = 1'b1;
        end else if (c >= 8'h4A && c <= 8'h4E) begin
            t = c - 8'h4A + 8'd17;
            d.ok = 1'b1;
        end else if (c >= 8'h50 && c <= 8'h5A) begin
            t = c - 8'h50 + 8'd22;
            d.ok = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h6B) begin
            t = c - 8'h61 + 8'd33;
            d.ok = 1'b1;
        end else if (c >= 8'h6D && c <= 8'h7A) begin
            t = c - 8'h6D + 8'd44;
            d.ok = 1'b1;
        end
        d.value = t[5:0];
        return d;
    endfunction

    // Byte count for a block of n characters; 0 for a length with no meaning
    function automatic logic [3:0] bytes_for_chars(input logic [3:0] n);
        logic [3:0] b;
        case (n)
            4'd2:    b = 4'd1;
            4'd3:    b = 4'd2;
            4'd5:    b = 4'd3;
            4'd6:    b = 4'd4;
            4'd7:    b = 4'd5;
            4'd9:    b = 4'd6;
            4'd10:   b = 4'd7;
            4'd11:   b = 4'd8;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

### sv/b58dec_front.sv
module b58dec_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  b58dec_pkg::t_in_item i_in_data,
    output logic                o_in_ready,
    input  logic                i_q_full,
    output logic                o_push,
    output b58dec_pkg::t_job    o_job
);
    import b58dec_pkg::*;

    logic [63:0] r_value, n_value;
    logic [3:0]  r_chars, n_chars;
    t_status     r_err, n_err;

    t_digit      dig;
    logic [69:0] wide;
    logic [69:0] acc;
    logic        ovf;
    t_status     err_a;
    t_status     err_f;
    logic [63:0] val_a;
    logic [3:0]  chars_a;
    logic [3:0]  nb;
    logic        full;
    logic        last;
    logic        accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign last       = i_in_data.last_symbol;

    // Horner step: value * 58 + digit, with 58 = 64 - 8 + 2
    always_comb begin
        dig  = digit_of(i_in_data.symbol);
        wide = {6'd0, r_value};
        acc  = (wide << 6) - (wide << 3) + (wide << 1) + {64'd0, dig.value};
        ovf  = |acc[69:64];
    end

    // Classify the character and build the block job
    always_comb begin
        err_a = r_err;
        val_a = r_value;
        if (r_err == ST_OK) begin
            if (!dig.ok) begin
                err_a = ST_BAD_SYMBOL;
            end else if (ovf) begin
                err_a = ST_OVERFLOW;
            end else begin
                val_a = acc[63:0];
            end
        end
        chars_a = r_chars + 4'd1;
        full    = (chars_a >= FULL_CHARS);
        nb      = bytes_for_chars(chars_a);

        // Length and fit checks on a short final block
        err_f = err_a;
        if (!full && last && err_a == ST_OK) begin
            if (nb == 4'd0) begin
                err_f = ST_BAD_LENGTH;
            end else if ((val_a >> {nb[2:0], 3'b000}) != 64'd0) begin
                err_f = ST_OVERFLOW;
            end
        end

        o_push = accept && (last || (full && err_a == ST_OK));
        if (err_f != ST_OK) begin
            o_job.value  = '0;
            o_job.nbytes = 4'd1;
            o_job.eos    = 1'b1;
            o_job.status = err_f;
        end else begin
            o_job.value  = val_a;
            o_job.nbytes = full ? FULL_BYTES : nb;
            o_job.eos    = last;
            o_job.status = ST_OK;
        end

        // Close the block at eleven characters or at the end mark
        n_value = val_a;
        n_chars = chars_a;
        n_err   = err_a;
        if (full || last) begin
            n_value = '0;
            n_chars = '0;
        end
        if (last) begin
            n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_chars <= '0;
            r_err   <= ST_OK;
        end else if (accept) begin
            r_value <= n_value;
            r_chars <= n_chars;
            r_err   <= n_err;
        end
    end

    a_chars_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chars < FULL_CHARS)
        else $error("character count left the block range");

endmodule

### sv/b58dec_fifo.sv
module b58dec_fifo #(
    parameter int DEPTH = b58dec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b58dec_pkg::t_job i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output b58dec_pkg::t_job o_head
);
    import b58dec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Write the tail entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("block queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("block queue read while empty");

endmodule

### sv/b58dec_back.sv
module b58dec_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  b58dec_pkg::t_job      i_q_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output b58dec_pkg::t_out_item o_out_data
);
    import b58dec_pkg::*;

    logic [63:0] r_shift;
    logic [3:0]  r_left;
    logic        r_eos;
    t_status     r_status;
    logic        r_active;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        take;
    logic        last_beat;
    logic [3:0]  pad;

    assign take      = r_active && (!r_out_valid || i_out_ready);
    assign last_beat = (r_left == 4'd1);
    assign o_pop     = !i_q_empty && (!r_active || (take && last_beat));
    assign pad       = FULL_BYTES - i_q_head.nbytes;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Serializer: load a job left-aligned, then shift out one byte per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_left   <= i_q_head.nbytes;
        end else if (take) begin
            r_left <= r_left - 4'd1;
            if (last_beat) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift  <= i_q_head.value << {pad[2:0], 3'b000};
            r_eos    <= i_q_head.eos;
            r_status <= i_q_head.status;
        end else if (take) begin
            r_shift <= r_shift << 8;
        end
    end

    // Output register: hold while stalled, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_item.out_byte      <= r_shift[63:56];
            r_out_item.end_of_block  <= last_beat;
            r_out_item.end_of_string <= last_beat && r_eos;
            r_out_item.status        <= r_status;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_left != 4'd0 && r_left <= FULL_BYTES))
        else $error("serializer byte count out of range");

    a_eos_closes_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.end_of_string) |-> r_out_item.end_of_block)
        else $error("end of string without end of block");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status != ST_OK) |->
            (r_out_item.out_byte == 8'd0 && r_out_item.end_of_string))
        else $error("error beat is not a lone closing beat");

endmodule

### sv/base58_block_decoder.sv
// Streaming base58 block decoder. One ASCII character is taken per beat on
// the input channel, last_symbol marking the end of the string; the block
// value is built combinationally as value*58+digit for each character, so the
// front takes one character every clock while the block queue has room.
// Eleven characters close a full block of 8 big-endian bytes; a final short
// block of 2, 3, 5, 6, 7, 9 or 10 characters gives 1 to 7 bytes. Finished
// blocks wait in a QUEUE_DEPTH-entry queue and a serializer sends one byte
// per clock while the output is ready. An invalid symbol, an overflow or a
// final block of 1, 4 or 8 characters is reported once, at the end of the
// string, as a single beat with out_byte 0 and a nonzero status; bytes
// already sent for that string stand and are to be discarded downstream.
module base58_block_decoder #(
    parameter int QUEUE_DEPTH = b58dec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  b58dec_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output b58dec_pkg::t_out_item o_out_data
);
    import b58dec_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    b58dec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    b58dec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    b58dec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
